/* rtl/mrsp_pkg.sv */
package mrsp_pkg;

  localparam logic [7:0] REALTIME_MIN   = 8'hF8;
  localparam logic [7:0] SYSEX_START    = 8'hF0;
  localparam logic [7:0] SYSCOMMON_MIN  = 8'hF1;
  localparam logic [7:0] NO_STATUS      = 8'h00;

  localparam logic [3:0] HI_NOTE_OFF    = 4'h8;
  localparam logic [3:0] HI_NOTE_ON     = 4'h9;
  localparam logic [3:0] HI_POLY_AT     = 4'hA;
  localparam logic [3:0] HI_CTRL_CHANGE = 4'hB;
  localparam logic [3:0] HI_PROG_CHANGE = 4'hC;
  localparam logic [3:0] HI_CHAN_AT     = 4'hD;
  localparam logic [3:0] HI_PITCH_BEND  = 4'hE;

  typedef enum logic [2:0] {
    KIND_NOTE_OFF    = 3'd0,
    KIND_NOTE_ON     = 3'd1,
    KIND_POLY_AT     = 3'd2,
    KIND_CTRL_CHANGE = 3'd3,
    KIND_CHAN_AT     = 3'd4,
    KIND_PITCH_BEND  = 3'd5
  } event_kind_t;

  typedef struct packed {
    event_kind_t kind;
    logic [4:0]  channel;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
  } event_t;

endpackage

/* rtl/mrsp_decode.sv */
module mrsp_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output mrsp_pkg::event_t  res_event
);

  logic [7:0] running_status_r, running_status_nxt;
  logic       in_sysex_r, in_sysex_nxt;
  logic       held_r, held_nxt;
  logic [6:0] held_data_r, held_data_nxt;

  mrsp_pkg::event_kind_t kind;
  logic                  kind_ok;
  logic                  one_byte_msg;

  // map status high nibble to event kind
  always_comb begin
    kind         = mrsp_pkg::KIND_NOTE_OFF;
    kind_ok      = 1'b0;
    one_byte_msg = 1'b0;
    unique case (running_status_r[7:4])
      mrsp_pkg::HI_NOTE_OFF:    begin kind = mrsp_pkg::KIND_NOTE_OFF;    kind_ok = 1'b1; end
      mrsp_pkg::HI_NOTE_ON:     begin kind = mrsp_pkg::KIND_NOTE_ON;     kind_ok = 1'b1; end
      mrsp_pkg::HI_POLY_AT:     begin kind = mrsp_pkg::KIND_POLY_AT;     kind_ok = 1'b1; end
      mrsp_pkg::HI_CTRL_CHANGE: begin kind = mrsp_pkg::KIND_CTRL_CHANGE; kind_ok = 1'b1; end
      mrsp_pkg::HI_PROG_CHANGE: begin one_byte_msg = 1'b1; end
      mrsp_pkg::HI_CHAN_AT: begin
        kind         = mrsp_pkg::KIND_CHAN_AT;
        kind_ok      = 1'b1;
        one_byte_msg = 1'b1;
      end
      mrsp_pkg::HI_PITCH_BEND:  begin kind = mrsp_pkg::KIND_PITCH_BEND;  kind_ok = 1'b1; end
      default:                  begin kind_ok = 1'b0; end
    endcase
  end

  always_comb begin
    running_status_nxt    = running_status_r;
    in_sysex_nxt          = in_sysex_r;
    held_nxt              = held_r;
    held_data_nxt         = held_data_r;
    res_valid             = 1'b0;
    res_event.kind        = kind;
    res_event.channel     = {1'b0, running_status_r[3:0]} + 5'd1;
    res_event.first_data  = held_data_r;
    res_event.second_data = rx_byte[6:0];
    if (step) begin
      priority if (rx_byte >= mrsp_pkg::REALTIME_MIN) begin
        // real-time bytes pass through without touching state
      end else if (rx_byte[7]) begin
        held_nxt = 1'b0;
        priority if (rx_byte == mrsp_pkg::SYSEX_START) begin
          in_sysex_nxt       = 1'b1;
          running_status_nxt = mrsp_pkg::NO_STATUS;
        end else if (rx_byte >= mrsp_pkg::SYSCOMMON_MIN) begin
          in_sysex_nxt       = 1'b0;
          running_status_nxt = mrsp_pkg::NO_STATUS;
        end else begin
          in_sysex_nxt       = 1'b0;
          running_status_nxt = rx_byte;
        end
      end else if (!in_sysex_r && (running_status_r != mrsp_pkg::NO_STATUS)) begin
        priority if (one_byte_msg) begin
          res_valid             = kind_ok;
          res_event.first_data  = rx_byte[6:0];
          res_event.second_data = 7'd0;
        end else if (!held_r) begin
          held_data_nxt = rx_byte[6:0];
          held_nxt      = 1'b1;
        end else begin
          held_nxt  = 1'b0;
          res_valid = kind_ok;
        end
      end else begin
        // data byte inside sysex or with no status: dropped
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_status_r <= mrsp_pkg::NO_STATUS;
      in_sysex_r       <= 1'b0;
      held_r           <= 1'b0;
    end else begin
      running_status_r <= running_status_nxt;
      in_sysex_r       <= in_sysex_nxt;
      held_r           <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_data_r <= held_data_nxt;
  end

endmodule

/* rtl/mrsp_out_reg.sv */
module mrsp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  mrsp_pkg::event_t  res_event,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_ready,
  output mrsp_pkg::event_t  out_event
);

  logic             valid_r, valid_nxt;
  mrsp_pkg::event_t event_r, event_nxt;

  // the stage may load whenever its slot is empty or being drained
  assign advance = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    event_nxt = event_r;
    if (advance) begin
      valid_nxt = res_valid;
      if (res_valid) begin
        event_nxt = res_event;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    event_r <= event_nxt;
  end

  assign out_valid = valid_r;
  assign out_event = event_r;

endmodule

/* rtl/midi_running_status_parser_top.sv */
// MIDI running-status parser: takes one received byte per transaction and
// returns one decoded channel voice event (kind, channel 1..16, two data
// bytes) when a message completes; program change messages yield no event.
// It accepts one byte every clock cycle; a byte passes an input register
// and the decode logic, and its event is then loaded into the output
// register. The input side keeps taking bytes while an event waits on
// the output, and only stalls when both registers hold work and out_ready
// stays low.
module midi_running_status_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_event_kind,
  output logic [4:0] out_channel_number,
  output logic [6:0] out_first_data,
  output logic [6:0] out_second_data
);

  logic             in_v_r, in_v_nxt;
  logic [7:0]       in_byte_r, in_byte_nxt;
  logic             advance;
  logic             step;
  logic             res_valid;
  mrsp_pkg::event_t res_event;
  mrsp_pkg::event_t out_event;

  assign in_ready = !in_v_r || advance;
  assign step     = in_v_r && advance;

  always_comb begin
    in_v_nxt    = in_v_r;
    in_byte_nxt = in_byte_r;
    if (in_valid && in_ready) begin
      in_v_nxt    = 1'b1;
      in_byte_nxt = in_rx_byte;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_byte_r <= in_byte_nxt;
  end

  mrsp_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (in_byte_r),
    .res_valid (res_valid),
    .res_event (res_event)
  );

  mrsp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_event (res_event),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_event (out_event)
  );

  assign out_event_kind     = out_event.kind;
  assign out_channel_number = out_event.channel;
  assign out_first_data     = out_event.first_data;
  assign out_second_data    = out_event.second_data;

endmodule
